// ===== rtl/kdhf_pkg.sv =====
package kdhf_pkg;

  localparam int STORE_SIDE = 256;
  localparam int ADDR_W = 16;
  localparam int DEPTH_W = 16;

  localparam int DEF_MAX_WIDTH = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int DEF_MAX_RADIUS = 7;
  localparam int DEF_MAX_NEIGHBORS = 64;

  localparam logic [1:0] REG_RADIUS = 2'd0;
  localparam logic [1:0] REG_COUNT = 2'd1;
  localparam logic [1:0] REG_WIDTH = 2'd2;
  localparam logic [1:0] REG_HEIGHT = 2'd3;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_READ = 1'b1;

  // commands from controller to datapath
  typedef struct packed {
    logic load_req;      // latch request coordinates and limits
    logic mem_we;        // write datapath request to store
    logic mem_rd_own;    // read own pixel
    logic mem_rd_scan;   // read current scan cell
    logic scan_init;     // reset scan to window start for current distance
    logic scan_step;     // advance scan cell
    logic dist_step;     // advance distance, restart scan
    logic accum;         // accumulate last read cell if it matches
    logic clr_ptr;       // clear clearing pointer
    logic clr_write;     // write zero at clearing pointer
    logic div_start;
    logic res_own;       // result is own value
    logic res_zero;
    logic res_div;
  } kdhf_cmd_t;

  typedef struct packed {
    logic out_of_frame;
    logic own_nonzero;
    logic scan_last;     // current cell is last of window
    logic dist_last;     // current distance is last
    logic full;          // taken reached k
    logic none;          // taken is zero
    logic clr_last;
    logic div_done;
  } kdhf_sts_t;

endpackage

// ===== rtl/kdhf_div.sv =====
module kdhf_div #(
  parameter int NW = 24,
  parameter int DW = 9
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quo,
  output logic          done
);
  localparam int CW = $clog2(NW + 1);
  logic [NW-1:0] q;
  logic [DW:0] rem;
  logic [CW-1:0] cnt;
  logic busy;
  logic [DW:0] trial;

  assign trial = {rem[DW-1:0], q[NW-1]};

  // restoring division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        q <= num;
        rem <= '0;
        cnt <= CW'(NW);
        busy <= 1'b1;
      end else if (busy) begin
        if (trial >= {1'b0, den}) begin
          rem <= trial - {1'b0, den};
          q <= {q[NW-2:0], 1'b1};
        end else begin
          rem <= trial;
          q <= {q[NW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
  assign quo = q;
endmodule

// ===== rtl/kdhf_datapath.sv =====
module kdhf_datapath #(
  parameter int MAX_WIDTH = kdhf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = kdhf_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_RADIUS = kdhf_pkg::DEF_MAX_RADIUS,
  parameter int MAX_NEIGHBORS = kdhf_pkg::DEF_MAX_NEIGHBORS
) (
  input  logic               clk,
  input  logic               rst,
  input  kdhf_pkg::kdhf_cmd_t cmd,
  output kdhf_pkg::kdhf_sts_t sts,
  input  logic [7:0]         in_row,
  input  logic [7:0]         in_col,
  input  logic [15:0]        in_depth,
  input  logic [2:0]         reg_radius,
  input  logic [6:0]         reg_count,
  input  logic [8:0]         reg_width,
  input  logic [8:0]         reg_height,
  output logic [7:0]         res_row,
  output logic [7:0]         res_col,
  output logic [15:0]        res_fill
);
  localparam int WLIM = (MAX_WIDTH < kdhf_pkg::STORE_SIDE) ? MAX_WIDTH : kdhf_pkg::STORE_SIDE;
  localparam int HLIM = (MAX_HEIGHT < kdhf_pkg::STORE_SIDE) ? MAX_HEIGHT : kdhf_pkg::STORE_SIDE;
  localparam int KW = $clog2(MAX_NEIGHBORS + 1);
  localparam int DSW = $clog2(2 * MAX_RADIUS * MAX_RADIUS + 1) + 1;
  localparam int SW = 16 + KW;

  logic [15:0] mem [0:65535];
  logic [15:0] rd_data;
  logic [15:0] addr_rd;
  logic [7:0] r, c;
  logic [8:0] w_e, h_e, top, bot, lft, rgt, y, x;
  logic [KW-1:0] k, taken;
  logic [SW-1:0] sum;
  logic [DSW-1:0] d, dmax, cell_d;
  logic [15:0] clr_ptr;
  logic rd_valid;
  logic [8:0] dy, dx;
  logic [SW-1:0] quo;

  always_comb begin
    if (reg_width == 9'd0) w_e = 9'd1;
    else if ({23'd0, reg_width} > WLIM) w_e = 9'(WLIM);
    else w_e = reg_width;
    if (reg_height == 9'd0) h_e = 9'd1;
    else if ({23'd0, reg_height} > HLIM) h_e = 9'(HLIM);
    else h_e = reg_height;
  end

  assign dy = (y >= {1'b0, r}) ? y - {1'b0, r} : {1'b0, r} - y;
  assign dx = (x >= {1'b0, c}) ? x - {1'b0, c} : {1'b0, c} - x;
  assign cell_d = DSW'({5'd0, dy[4:0]} * {5'd0, dy[4:0]} + {5'd0, dx[4:0]} * {5'd0, dx[4:0]});

  assign addr_rd = cmd.mem_rd_own ? {r, c} : {y[7:0], x[7:0]};

  always_ff @(posedge clk) begin
    if (cmd.clr_write) mem[clr_ptr] <= '0;
    else if (cmd.mem_we) mem[{in_row, in_col}] <= in_depth;
    if (cmd.mem_rd_own || cmd.mem_rd_scan) rd_data <= mem[addr_rd];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_ptr <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (cmd.clr_ptr) clr_ptr <= '0;
      else if (cmd.clr_write) clr_ptr <= clr_ptr + 1'b1;
      rd_valid <= cmd.mem_rd_scan && (cell_d == d);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      logic [3:0] rq;
      logic [7:0] kq;
      rq = ({28'd0, reg_radius} > MAX_RADIUS) ? 4'(MAX_RADIUS) : {1'b0, reg_radius};
      kq = (reg_count == 7'd0) ? 8'd1 :
           (({25'd0, reg_count} > MAX_NEIGHBORS) ? 8'(MAX_NEIGHBORS) : {1'b0, reg_count});
      r <= in_row;
      c <= in_col;
      k <= KW'(kq);
      taken <= '0;
      sum <= '0;
      d <= '0;
      dmax <= DSW'(2 * rq * rq);
      top <= ({1'b0, in_row} >= {5'd0, rq}) ? {1'b0, in_row} - {5'd0, rq} : 9'd0;
      bot <= ({1'b0, in_row} + {5'd0, rq} + 9'd1 < h_e) ? {1'b0, in_row} + {5'd0, rq} : h_e - 9'd1;
      lft <= ({1'b0, in_col} >= {5'd0, rq}) ? {1'b0, in_col} - {5'd0, rq} : 9'd0;
      rgt <= ({1'b0, in_col} + {5'd0, rq} + 9'd1 < w_e) ? {1'b0, in_col} + {5'd0, rq} : w_e - 9'd1;
    end
    if (cmd.scan_init || cmd.dist_step) begin
      y <= top;
      x <= lft;
    end else if (cmd.scan_step) begin
      if (x == rgt) begin
        x <= lft;
        y <= y + 9'd1;
      end else begin
        x <= x + 9'd1;
      end
    end
    if (cmd.dist_step) d <= d + 1'b1;
    if (cmd.accum && rd_valid && rd_data != 16'd0 && taken != k) begin
      sum <= sum + SW'(rd_data);
      taken <= taken + 1'b1;
    end
    if (cmd.res_own) res_fill <= rd_data;
    else if (cmd.res_zero) res_fill <= '0;
    else if (cmd.res_div) res_fill <= quo[15:0];
    if (cmd.load_req) begin
      res_row <= in_row;
      res_col <= in_col;
    end
  end

  kdhf_div #(.NW(SW), .DW(KW)) u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start), .num(sum), .den(taken),
    .quo(quo), .done(sts.div_done)
  );

  assign sts.out_of_frame = ({1'b0, r} >= h_e) || ({1'b0, c} >= w_e);
  assign sts.own_nonzero = rd_data != 16'd0;
  assign sts.scan_last = (x == rgt) && (y == bot);
  assign sts.dist_last = d == dmax;
  assign sts.full = taken == k;
  assign sts.none = taken == '0;
  assign sts.clr_last = clr_ptr == 16'hFFFF;
endmodule

// ===== rtl/kdhf_ctrl.sv =====
module kdhf_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_action,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output kdhf_pkg::kdhf_cmd_t cmd,
  input  kdhf_pkg::kdhf_sts_t sts
);
  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_OWN, S_OWN_CHK, S_SCAN, S_DRAIN, S_NEXT, S_DIV, S_DIV_WAIT, S_OUT
  } state_t;
  state_t state;

  assign in_ready = (state == S_IDLE) || (state == S_OUT && out_ready);
  logic acc;
  assign acc = in_valid && in_ready;

  always_comb begin
    cmd = '0;
    cmd.clr_write = state == S_CLEAR;
    cmd.mem_we = acc && in_action == kdhf_pkg::ACT_WRITE;
    cmd.load_req = acc && in_action == kdhf_pkg::ACT_READ;
    cmd.mem_rd_own = state == S_OWN;
    cmd.mem_rd_scan = state == S_SCAN;
    cmd.scan_step = state == S_SCAN;
    cmd.accum = (state == S_SCAN) || (state == S_DRAIN);
    cmd.scan_init = state == S_OWN_CHK;
    cmd.dist_step = state == S_NEXT && !sts.dist_last && !sts.full;
    cmd.div_start = state == S_DIV;
    cmd.res_own = state == S_OWN_CHK && !sts.out_of_frame && sts.own_nonzero;
    cmd.res_zero = (state == S_OWN_CHK && sts.out_of_frame) ||
                   (state == S_DIV && sts.none);
    cmd.res_div = state == S_DIV_WAIT && sts.div_done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: if (sts.clr_last) state <= S_IDLE;
        S_OWN: state <= S_OWN_CHK;
        S_OWN_CHK: begin
          if (sts.out_of_frame || sts.own_nonzero) begin
            state <= S_OUT;
            out_valid <= 1'b1;
          end else state <= S_SCAN;
        end
        S_SCAN: if (sts.scan_last) state <= S_DRAIN;
        S_DRAIN: state <= S_NEXT;
        S_NEXT: state <= (sts.dist_last || sts.full) ? S_DIV : S_SCAN;
        S_DIV: begin
          if (sts.none) begin
            state <= S_OUT;
            out_valid <= 1'b1;
          end else state <= S_DIV_WAIT;
        end
        S_DIV_WAIT: if (sts.div_done) begin
          state <= S_OUT;
          out_valid <= 1'b1;
        end
        S_IDLE, S_OUT: begin
          if (acc && in_action == kdhf_pkg::ACT_READ) state <= S_OWN;
          else if (state == S_OUT && out_ready) state <= S_IDLE;
          if (state == S_OUT && out_ready) out_valid <= 1'b0;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/knn_depth_hole_fill.sv =====
// write: the depth goes straight into the store. read: a stored, nonzero or out-of-frame
// pixel answers with its own value or zero without a scan, else up to (2*r*r+1) window
// passes over the single store read port, then the bit-serial divide.
// one item at a time; a result waits in an output register until taken.
// synchronous reset clears the 65536-entry store in one pass during which no request
// is accepted; config writes are taken at all times.
module knn_depth_hole_fill #(
  parameter int MAX_WIDTH = kdhf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = kdhf_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_RADIUS = kdhf_pkg::DEF_MAX_RADIUS,
  parameter int MAX_NEIGHBORS = kdhf_pkg::DEF_MAX_NEIGHBORS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // row[7:0], col[15:8], depth[31:16]
  input  logic        s_axis_tuser,   // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // out_row[7:0], out_col[15:8], filled_depth[31:16]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data
);
  kdhf_pkg::kdhf_cmd_t cmd;
  kdhf_pkg::kdhf_sts_t sts;
  logic [2:0] reg_radius;
  logic [6:0] reg_count;
  logic [8:0] reg_width, reg_height;
  logic [7:0] res_row, res_col;
  logic [15:0] res_fill;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      reg_radius <= 3'd2;
      reg_count <= 7'd4;
      reg_width <= 9'd256;
      reg_height <= 9'd256;
    end else if (cfg_valid) begin
      case (cfg_index)
        kdhf_pkg::REG_RADIUS: reg_radius <= cfg_data[2:0];
        kdhf_pkg::REG_COUNT: reg_count <= cfg_data[6:0];
        kdhf_pkg::REG_WIDTH: reg_width <= cfg_data;
        kdhf_pkg::REG_HEIGHT: reg_height <= cfg_data;
        default: ;
      endcase
    end
  end

  kdhf_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_axis_tvalid), .in_action(s_axis_tuser),
    .in_ready(s_axis_tready), .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .cmd(cmd), .sts(sts)
  );

  kdhf_datapath #(
    .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT),
    .MAX_RADIUS(MAX_RADIUS), .MAX_NEIGHBORS(MAX_NEIGHBORS)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .in_row(s_axis_tdata[7:0]), .in_col(s_axis_tdata[15:8]), .in_depth(s_axis_tdata[31:16]),
    .reg_radius(reg_radius), .reg_count(reg_count), .reg_width(reg_width),
    .reg_height(reg_height), .res_row(res_row), .res_col(res_col), .res_fill(res_fill)
  );

  assign m_axis_tdata = {res_fill, res_col, res_row};

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("request accepted while result pending");
  a_mem_excl: assert property (@(posedge clk) disable iff (rst)
    !(cmd.clr_write && cmd.mem_we))
    else $error("store write during clear");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");
`endif
endmodule
